// ----- sv/lts_pkg.sv -----
// shared types, token codes and keyword lookup for the token scanner
`timescale 1ns / 1ps
package lts_pkg;
    localparam int POS_BITS    = 24;
    localparam int LINE_BITS   = 24;
    localparam int KIND_BITS   = 6;
    localparam int ERR_BITS    = 2;
    localparam int MAX_RES     = 4;
    localparam int CNT_BITS    = $clog2(MAX_RES + 1);
    localparam int IDX_BITS    = $clog2(MAX_RES);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_BITS-1:0] K_LPAREN = 6'd0;
    localparam logic [KIND_BITS-1:0] K_RPAREN = 6'd1;
    localparam logic [KIND_BITS-1:0] K_LBRACE = 6'd2;
    localparam logic [KIND_BITS-1:0] K_RBRACE = 6'd3;
    localparam logic [KIND_BITS-1:0] K_COMMA  = 6'd4;
    localparam logic [KIND_BITS-1:0] K_DOT    = 6'd5;
    localparam logic [KIND_BITS-1:0] K_MINUS  = 6'd6;
    localparam logic [KIND_BITS-1:0] K_PLUS   = 6'd7;
    localparam logic [KIND_BITS-1:0] K_SEMI   = 6'd8;
    localparam logic [KIND_BITS-1:0] K_SLASH  = 6'd9;
    localparam logic [KIND_BITS-1:0] K_STAR   = 6'd10;
    localparam logic [KIND_BITS-1:0] K_BANG   = 6'd11;
    localparam logic [KIND_BITS-1:0] K_EQUAL  = 6'd13;
    localparam logic [KIND_BITS-1:0] K_GREATER = 6'd15;
    localparam logic [KIND_BITS-1:0] K_LESS   = 6'd17;
    localparam logic [KIND_BITS-1:0] K_IDENT  = 6'd19;
    localparam logic [KIND_BITS-1:0] K_STRING = 6'd20;
    localparam logic [KIND_BITS-1:0] K_NUMBER = 6'd21;
    localparam logic [KIND_BITS-1:0] K_AND    = 6'd22;
    localparam logic [KIND_BITS-1:0] K_CLASS  = 6'd23;
    localparam logic [KIND_BITS-1:0] K_ELSE   = 6'd24;
    localparam logic [KIND_BITS-1:0] K_FALSE  = 6'd25;
    localparam logic [KIND_BITS-1:0] K_FUN    = 6'd26;
    localparam logic [KIND_BITS-1:0] K_FOR    = 6'd27;
    localparam logic [KIND_BITS-1:0] K_IF     = 6'd28;
    localparam logic [KIND_BITS-1:0] K_NIL    = 6'd29;
    localparam logic [KIND_BITS-1:0] K_OR     = 6'd30;
    localparam logic [KIND_BITS-1:0] K_PRINT  = 6'd31;
    localparam logic [KIND_BITS-1:0] K_RETURN = 6'd32;
    localparam logic [KIND_BITS-1:0] K_SUPER  = 6'd33;
    localparam logic [KIND_BITS-1:0] K_THIS   = 6'd34;
    localparam logic [KIND_BITS-1:0] K_TRUE   = 6'd35;
    localparam logic [KIND_BITS-1:0] K_VAR    = 6'd36;
    localparam logic [KIND_BITS-1:0] K_WHILE  = 6'd37;
    localparam logic [KIND_BITS-1:0] K_EOF    = 6'd38;
    localparam logic [KIND_BITS-1:0] K_NONE   = 6'd39;

    localparam logic [ERR_BITS-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_UNTERM     = 2'd2;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [POS_BITS-1:0]  start;
        logic [POS_BITS-1:0]  len;
        logic [LINE_BITS-1:0] line;
        logic [ERR_BITS-1:0]  err;
    } tok_t;

    typedef struct packed {
        tok_t [MAX_RES-1:0]  res;
        logic [CNT_BITS-1:0] cnt;
    } bundle_t;

    // prefix holds the first byte in the low bits
    function automatic logic [KIND_BITS-1:0] keyword_kind(input logic [47:0] prefix,
                                                         input logic [2:0] wlen);
        logic [KIND_BITS-1:0] k;
        k = K_IDENT;
        case (wlen)
            3'd2:
            begin
                if (prefix == 48'("fi")) k = K_IF;
                if (prefix == 48'("ro")) k = K_OR;
            end
            3'd3:
            begin
                if (prefix == 48'("dna")) k = K_AND;
                if (prefix == 48'("nuf")) k = K_FUN;
                if (prefix == 48'("rof")) k = K_FOR;
                if (prefix == 48'("lin")) k = K_NIL;
                if (prefix == 48'("rav")) k = K_VAR;
            end
            3'd4:
            begin
                if (prefix == 48'("esle")) k = K_ELSE;
                if (prefix == 48'("siht")) k = K_THIS;
                if (prefix == 48'("eurt")) k = K_TRUE;
            end
            3'd5:
            begin
                if (prefix == 48'("ssalc")) k = K_CLASS;
                if (prefix == 48'("eslaf")) k = K_FALSE;
                if (prefix == 48'("tnirp")) k = K_PRINT;
                if (prefix == 48'("repus")) k = K_SUPER;
                if (prefix == 48'("elihw")) k = K_WHILE;
            end
            3'd6:
            begin
                if (prefix == 48'("nruter")) k = K_RETURN;
            end
            default:
            begin
                k = K_IDENT;
            end
        endcase
        return k;
    endfunction

    function automatic logic [KIND_BITS-1:0] op_base(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            "!":     k = K_BANG;
            "=":     k = K_EQUAL;
            ">":     k = K_GREATER;
            default: k = K_LESS;
        endcase
        return k;
    endfunction
endpackage

// ----- sv/lexical_token_scanner.sv -----
// top level of the lexical token scanner
// usage
//   input channel: one source byte per transaction on char_byte with has_char
//   set; end_of_source on the same or a later transaction flushes any open
//   token and adds an end-of-file token if the bundle has room, then the
//   scanner returns to reset state ready for the next source
//   output channel: one token or error per transaction; last_of_run marks the
//   final token caused by one input transaction
// throughput
//   the front end classifies a byte in the cycle it is accepted, so one byte
//   per cycle is taken while the queue has room; tokens appear in the cycle
//   after acceptance at the earliest
//   the output stage sends one token per cycle unless out_stall is high, so
//   a byte that causes k tokens takes k output transactions; a four-entry
//   bundle queue absorbs bursts and in_stall rises only when it is full
// reset
//   rst_n clears mode, counters (line count to one) and empties the queue
// stall
//   with out_stall high the current token holds and the queue fills; input
//   keeps flowing until four bundles wait
`timescale 1ns / 1ps
module lexical_token_scanner
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [7:0]                             char_byte,
    input  logic                                   has_char,
    input  logic                                   end_of_source,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [lts_pkg::KIND_BITS-1:0]          token_kind,
    output logic [lts_pkg::POS_BITS-1:0]           start_offset,
    output logic [lts_pkg::POS_BITS-1:0]           token_length,
    output logic [lts_pkg::LINE_BITS-1:0]          line_number,
    output logic [lts_pkg::ERR_BITS-1:0]           error_code,
    output logic                                   last_of_run
);
    logic                take;
    logic                q_full, q_have, q_pop;
    lts_pkg::bundle_t    bundle, head;

    // accept whenever the bundle queue has room
    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    lts_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .char_byte     (char_byte),
        .has_char      (has_char),
        .end_of_source (end_of_source),
        .bundle        (bundle)
    );

    // bytes that make no token push nothing
    lts_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && (bundle.cnt != '0)),
        .push_data (bundle),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_have),
        .head      (head)
    );

    lts_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .have         (q_have),
        .head         (head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_number  (line_number),
        .error_code   (error_code),
        .last_of_run  (last_of_run)
    );
endmodule

// ----- sv/lts_front.sv -----
// scan front end: mode machine that turns one byte into a bundle of tokens
`timescale 1ns / 1ps
module lts_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          char_byte,
    input  logic                has_char,
    input  logic                end_of_source,
    output lts_pkg::bundle_t    bundle
);
    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_OP       = 4'd1;
    localparam logic [3:0] M_SLASH    = 4'd2;
    localparam logic [3:0] M_COMMENT  = 4'd3;
    localparam logic [3:0] M_STRING   = 4'd4;
    localparam logic [3:0] M_NUMBER   = 4'd5;
    localparam logic [3:0] M_NUMDOT   = 4'd6;
    localparam logic [3:0] M_FRACTION = 4'd7;
    localparam logic [3:0] M_IDENT    = 4'd8;

    // control characters by code
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic [lts_pkg::POS_BITS-1:0]  POS_MAX  = '1;
    localparam logic [lts_pkg::LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [lts_pkg::POS_BITS-1:0]  ONE_POS  = lts_pkg::POS_BITS'(1);
    localparam logic [lts_pkg::LINE_BITS-1:0] ONE_LINE = lts_pkg::LINE_BITS'(1);

    logic [3:0]                      mode_reg, mode_next;
    logic [lts_pkg::POS_BITS-1:0]    pos_reg, pos_next;
    logic [lts_pkg::POS_BITS-1:0]    start_reg, start_next;
    logic [lts_pkg::LINE_BITS-1:0]   line_reg, line_next;
    logic [47:0]                     prefix_reg, prefix_next;
    logic [2:0]                      wlen_reg, wlen_next;
    logic [7:0]                      pend_reg, pend_next;

    logic [lts_pkg::POS_BITS-1:0]    p, n, fp;
    logic                            again;
    logic                            is_dig, is_alpha;
    lts_pkg::bundle_t                b;

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        wlen_next   = wlen_reg;
        pend_next   = pend_reg;
        b           = '0;
        again       = 1'b0;
        p           = pos_reg;
        n           = (pos_reg != POS_MAX) ? pos_reg + ONE_POS : pos_reg;
        is_dig      = (char_byte >= "0") && (char_byte <= "9");
        is_alpha    = ((char_byte >= "a") && (char_byte <= "z"))
                   || ((char_byte >= "A") && (char_byte <= "Z")) || (char_byte == "_");
        fp          = '0;

        if (has_char)
        begin
            unique case (mode_next)
                M_OP:
                begin
                    if (char_byte == "=")
                    begin
                        b.res[b.cnt[1:0]] = '{lts_pkg::op_base(pend_next) + 6'd1, start_next,
                                              n - start_next, line_next, lts_pkg::ERR_NONE};
                        b.cnt = b.cnt + 3'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        b.res[b.cnt[1:0]] = '{lts_pkg::op_base(pend_next), start_next,
                                              p - start_next, line_next, lts_pkg::ERR_NONE};
                        b.cnt = b.cnt + 3'd1;
                        again = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (char_byte == "/")
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        b.res[b.cnt[1:0]] = '{lts_pkg::K_SLASH, start_next, p - start_next,
                                              line_next, lts_pkg::ERR_NONE};
                        b.cnt = b.cnt + 3'd1;
                        again = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (char_byte == CH_LF)
                    begin
                        if (line_next != LINE_MAX) line_next = line_next + ONE_LINE;
                        mode_next = M_IDLE;
                    end
                end
                M_STRING:
                begin
                    if (char_byte == "\"")
                    begin
                        b.res[b.cnt[1:0]] = '{lts_pkg::K_STRING, start_next, n - start_next,
                                              line_next, lts_pkg::ERR_NONE};
                        b.cnt = b.cnt + 3'd1;
                        mode_next = M_IDLE;
                    end
                    else if (char_byte == CH_LF)
                    begin
                        if (line_next != LINE_MAX) line_next = line_next + ONE_LINE;
                    end
                end
                M_NUMBER:
                begin
                    if (char_byte == ".")
                    begin
                        mode_next = M_NUMDOT;
                    end
                    else if (!is_dig)
                    begin
                        b.res[b.cnt[1:0]] = '{lts_pkg::K_NUMBER, start_next, p - start_next,
                                              line_next, lts_pkg::ERR_NONE};
                        b.cnt = b.cnt + 3'd1;
                        again = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_dig)
                    begin
                        mode_next = M_FRACTION;
                    end
                    else
                    begin
                        b.res[b.cnt[1:0]] = '{lts_pkg::K_NUMBER, start_next,
                                              p - ONE_POS - start_next, line_next,
                                              lts_pkg::ERR_NONE};
                        b.cnt = b.cnt + 3'd1;
                        b.res[b.cnt[1:0]] = '{lts_pkg::K_DOT, p - ONE_POS, ONE_POS,
                                              line_next, lts_pkg::ERR_NONE};
                        b.cnt = b.cnt + 3'd1;
                        again = 1'b1;
                    end
                end
                M_FRACTION:
                begin
                    if (!is_dig)
                    begin
                        b.res[b.cnt[1:0]] = '{lts_pkg::K_NUMBER, start_next, p - start_next,
                                              line_next, lts_pkg::ERR_NONE};
                        b.cnt = b.cnt + 3'd1;
                        again = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha || is_dig)
                    begin
                        if (wlen_next < 3'd6)
                        begin
                            prefix_next[{wlen_next, 3'b000} +: 8] = char_byte;
                            wlen_next = wlen_next + 3'd1;
                        end
                        else
                        begin
                            wlen_next = 3'd7;
                        end
                    end
                    else
                    begin
                        b.res[b.cnt[1:0]] = '{lts_pkg::keyword_kind(prefix_next, wlen_next),
                                              start_next, p - start_next, line_next,
                                              lts_pkg::ERR_NONE};
                        b.cnt = b.cnt + 3'd1;
                        again = 1'b1;
                    end
                end
                default:
                begin
                    again = 1'b1;
                end
            endcase

            if (again)
            begin
                mode_next = M_IDLE;
                case (char_byte)
                    "(": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_LPAREN, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    ")": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_RPAREN, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    "{": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_LBRACE, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    "}": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_RBRACE, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    ",": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_COMMA, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    ".": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_DOT, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    "-": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_MINUS, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    "+": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_PLUS, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    ";": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_SEMI, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    "*": begin b.res[b.cnt[1:0]] = '{lts_pkg::K_STAR, p, n - p, line_next,
                                     lts_pkg::ERR_NONE}; b.cnt = b.cnt + 3'd1; end
                    "!", "=", "<", ">":
                    begin
                        mode_next  = M_OP;
                        pend_next  = char_byte;
                        start_next = p;
                    end
                    "/":
                    begin
                        mode_next  = M_SLASH;
                        start_next = p;
                    end
                    " ", CH_CR, CH_TAB:
                    begin
                    end
                    CH_LF:
                    begin
                        if (line_next != LINE_MAX) line_next = line_next + ONE_LINE;
                    end
                    "\"":
                    begin
                        mode_next  = M_STRING;
                        start_next = p;
                    end
                    default:
                    begin
                        if (is_dig)
                        begin
                            mode_next  = M_NUMBER;
                            start_next = p;
                        end
                        else if (is_alpha)
                        begin
                            mode_next   = M_IDENT;
                            start_next  = p;
                            prefix_next = {40'd0, char_byte};
                            wlen_next   = 3'd1;
                        end
                        else
                        begin
                            b.res[b.cnt[1:0]] = '{lts_pkg::K_NONE, p, n - p, line_next,
                                                  lts_pkg::ERR_UNEXPECTED};
                            b.cnt = b.cnt + 3'd1;
                        end
                    end
                endcase
            end
            pos_next = n;
        end

        if (end_of_source)
        begin
            fp = pos_next;
            unique case (mode_next)
                M_OP:
                begin
                    b.res[b.cnt[1:0]] = '{lts_pkg::op_base(pend_next), start_next,
                                          fp - start_next, line_next, lts_pkg::ERR_NONE};
                    b.cnt = b.cnt + 3'd1;
                end
                M_SLASH:
                begin
                    b.res[b.cnt[1:0]] = '{lts_pkg::K_SLASH, start_next, fp - start_next,
                                          line_next, lts_pkg::ERR_NONE};
                    b.cnt = b.cnt + 3'd1;
                end
                M_STRING:
                begin
                    b.res[b.cnt[1:0]] = '{lts_pkg::K_NONE, start_next, fp - start_next,
                                          line_next, lts_pkg::ERR_UNTERM};
                    b.cnt = b.cnt + 3'd1;
                end
                M_NUMBER, M_FRACTION:
                begin
                    b.res[b.cnt[1:0]] = '{lts_pkg::K_NUMBER, start_next, fp - start_next,
                                          line_next, lts_pkg::ERR_NONE};
                    b.cnt = b.cnt + 3'd1;
                end
                M_NUMDOT:
                begin
                    b.res[b.cnt[1:0]] = '{lts_pkg::K_NUMBER, start_next,
                                          fp - ONE_POS - start_next, line_next,
                                          lts_pkg::ERR_NONE};
                    b.cnt = b.cnt + 3'd1;
                    b.res[b.cnt[1:0]] = '{lts_pkg::K_DOT, fp - ONE_POS, ONE_POS, line_next,
                                          lts_pkg::ERR_NONE};
                    b.cnt = b.cnt + 3'd1;
                end
                M_IDENT:
                begin
                    b.res[b.cnt[1:0]] = '{lts_pkg::keyword_kind(prefix_next, wlen_next),
                                          start_next, fp - start_next, line_next,
                                          lts_pkg::ERR_NONE};
                    b.cnt = b.cnt + 3'd1;
                end
                default:
                begin
                end
            endcase
            // a bundle holds at most four tokens, a fifth end-of-file is dropped
            if (b.cnt < lts_pkg::CNT_BITS'(lts_pkg::MAX_RES))
            begin
                b.res[b.cnt[1:0]] = '{lts_pkg::K_EOF, fp, '0, line_next, lts_pkg::ERR_NONE};
                b.cnt = b.cnt + 3'd1;
            end

            mode_next   = M_IDLE;
            pos_next    = '0;
            start_next  = '0;
            line_next   = ONE_LINE;
            prefix_next = '0;
            wlen_next   = '0;
            pend_next   = '0;
        end
    end

    assign bundle = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            line_reg   <= lts_pkg::LINE_BITS'(1);
            prefix_reg <= '0;
            wlen_reg   <= '0;
            pend_reg   <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            wlen_reg   <= wlen_next;
            pend_reg   <= pend_next;
        end
    end
endmodule

// ----- sv/lts_queue.sv -----
// short queue of token bundles between scan front end and output stage
`timescale 1ns / 1ps
module lts_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lts_pkg::bundle_t    push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output lts_pkg::bundle_t    head
);
    lts_pkg::bundle_t                 mem_reg [lts_pkg::QUEUE_DEPTH];
    logic [lts_pkg::QPTR_BITS-1:0]    wr_reg, rd_reg;
    logic [lts_pkg::QCNT_BITS-1:0]    cnt_reg;

    assign full      = (cnt_reg == lts_pkg::QCNT_BITS'(lts_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + lts_pkg::QPTR_BITS'(1);
            if (pop)  rd_reg <= rd_reg + lts_pkg::QPTR_BITS'(1);
            if (push && !pop)      cnt_reg <= cnt_reg + lts_pkg::QCNT_BITS'(1);
            else if (pop && !push) cnt_reg <= cnt_reg - lts_pkg::QCNT_BITS'(1);
        end
    end
endmodule

// ----- sv/lts_back.sv -----
// output stage: walks the head bundle one token per transaction
`timescale 1ns / 1ps
module lts_back
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   have,
    input  lts_pkg::bundle_t                       head,
    output logic                                   pop,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [lts_pkg::KIND_BITS-1:0]          token_kind,
    output logic [lts_pkg::POS_BITS-1:0]           start_offset,
    output logic [lts_pkg::POS_BITS-1:0]           token_length,
    output logic [lts_pkg::LINE_BITS-1:0]          line_number,
    output logic [lts_pkg::ERR_BITS-1:0]           error_code,
    output logic                                   last_of_run
);
    logic [lts_pkg::IDX_BITS-1:0] idx_reg;
    lts_pkg::tok_t                cur;

    assign cur          = head.res[idx_reg];
    assign out_valid    = have;
    assign token_kind   = cur.kind;
    assign start_offset = cur.start;
    assign token_length = cur.len;
    assign line_number  = cur.line;
    assign error_code   = cur.err;
    assign last_of_run  = ({1'b0, idx_reg} == head.cnt - lts_pkg::CNT_BITS'(1));
    assign pop          = have && !out_stall && last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (have && !out_stall)
        begin
            idx_reg <= last_of_run ? '0 : idx_reg + lts_pkg::IDX_BITS'(1);
        end
    end
endmodule

// ----- sv/lts_checker.sv -----
// port-level assertions for the token scanner and their binding
`timescale 1ns / 1ps
module lts_checker
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic [lts_pkg::KIND_BITS-1:0]          token_kind,
    input logic [lts_pkg::POS_BITS-1:0]           token_length,
    input logic [lts_pkg::ERR_BITS-1:0]           error_code,
    input logic                                   last_of_run
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == lts_pkg::K_EOF) |-> last_of_run)
        else $error("end-of-file token not last of run");

    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == lts_pkg::K_EOF)
        |-> (token_length == '0) && (error_code == lts_pkg::ERR_NONE))
        else $error("malformed end-of-file token");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != lts_pkg::ERR_NONE) |-> (token_kind == lts_pkg::K_NONE))
        else $error("error reported with a token kind");
endmodule

bind lexical_token_scanner lts_checker u_lts_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_length (token_length),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
);
